// ----- src/motion_mode_crossfade_selector_core_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the motion mode cross-fade selector
// Shared property wrappers, clocked on the rising edge and held off in reset.
// ----------------------------------------------------------------------------
`ifndef MOTION_MODE_CROSSFADE_SELECTOR_CORE_MACROS_SVH
`define MOTION_MODE_CROSSFADE_SELECTOR_CORE_MACROS_SVH

// Same-cycle implication.
`define MMCS_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("mmcs check failed");

// Next-cycle implication.
`define MMCS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("mmcs check failed");

`endif

// ----- src/mmcs_pkg.sv -----
// ----------------------------------------------------------------------------
// mmcs_pkg
// Types and constants of the motion mode cross-fade selector.
// ----------------------------------------------------------------------------
package mmcs_pkg;

  localparam int unsigned NumMotions = 4;

  localparam logic [1:0] MOT_WALK    = 2'd0;
  localparam logic [1:0] MOT_BIKE    = 2'd1;
  localparam logic [1:0] MOT_SPECIAL = 2'd2;
  localparam logic [1:0] MOT_STAND   = 2'd3;

  localparam logic [1:0] MODE_INACTIVE = 2'd0;
  localparam logic [1:0] MODE_FIRST    = 2'd1;
  localparam logic [1:0] MODE_ACTIVE   = 2'd2;

  localparam logic [2:0] REG_USE_CONTACT   = 3'd0;
  localparam logic [2:0] REG_TIME_WALK     = 3'd1;
  localparam logic [2:0] REG_TIME_BIKE     = 3'd2;
  localparam logic [2:0] REG_TIME_SPECIAL  = 3'd3;
  localparam logic [2:0] REG_TIME_STAND    = 3'd4;
  localparam logic [2:0] REG_TIME_PLAYDEAD = 3'd5;

  localparam logic [15:0] ONE_Q15   = 16'h8000;
  localparam logic [8:0]  SA_NONE   = 9'd256;
  localparam logic [8:0]  SA_DEFAULT = 9'd0;

  typedef struct packed {
    logic [1:0]  requested_motion;
    logic [7:0]  special_action;
    logic        special_is_stand_up;
    logic        special_is_play_dead;
    logic        contact_safe;
    logic        enforce_stand;
    logic        leaving_possible;
    logic [31:0] time_ms;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  target_motion;
    logic [15:0] ratio_walk;
    logic [15:0] ratio_bike;
    logic [15:0] ratio_special;
    logic [15:0] ratio_stand;
    logic [1:0]  special_mode;
    logic [8:0]  special_action_out;
    logic        walk_forward;
    logic        bike_forward;
  } out_item_t;

  typedef struct packed {
    logic        use_contact;
    logic [15:0] time_walk;
    logic [15:0] time_bike;
    logic [15:0] time_special;
    logic [15:0] time_stand;
    logic [15:0] time_play_dead;
  } cfg_t;

  typedef struct packed {
    logic [18:0] rem;
    logic [16:0] bits;
    logic [18:0] den;
    logic [4:0]  steps;
  } div_req_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DELTA,
    ST_DWAIT,
    ST_SUM,
    ST_NORM,
    ST_NWAIT,
    ST_FIN
  } back_state_e;

endpackage

// ----- src/mmcs_front.sv -----
// ----------------------------------------------------------------------------
// mmcs_front
// Input side: takes frame transfers into a two-entry queue for the engine.
// ----------------------------------------------------------------------------
module mmcs_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  mmcs_pkg::in_item_t in_data_i,
  output logic               pop_valid_o,
  output mmcs_pkg::in_item_t pop_data_o,
  input  logic               pop_i
);

  mmcs_pkg::in_item_t mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q;
  logic       push, pop;

  assign in_stall_o  = (cnt_q == 2'd2);
  assign push        = in_valid_i && !in_stall_o;
  assign pop_valid_o = (cnt_q != 2'd0);
  assign pop         = pop_i && pop_valid_o;
  assign pop_data_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= in_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push) wr_ptr_q <= ~wr_ptr_q;
      if (pop)  rd_ptr_q <= ~rd_ptr_q;
      case ({push, pop})
        2'b10:   cnt_q <= cnt_q + 2'd1;
        2'b01:   cnt_q <= cnt_q - 2'd1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

// ----- src/mmcs_div.sv -----
// ----------------------------------------------------------------------------
// mmcs_div
// Shared restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module mmcs_div (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  mmcs_pkg::div_req_t req_i,
  output logic               done_o,
  output logic [16:0]        quot_o
);

  logic [18:0] rem_q;
  logic [16:0] bits_q;
  logic [18:0] den_q;
  logic [4:0]  cnt_q;
  logic [16:0] quot_q;
  logic        busy_q, done_q;
  logic [19:0] trial;
  logic        ge;

  assign trial  = {rem_q, bits_q[16]};
  assign ge     = (trial >= {1'b0, den_q});
  assign done_o = done_q;
  assign quot_o = quot_q;

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q  <= req_i.rem;
      bits_q <= req_i.bits;
      den_q  <= req_i.den;
      quot_q <= '0;
    end else if (busy_q) begin
      rem_q  <= ge ? 19'(trial - {1'b0, den_q}) : trial[18:0];
      bits_q <= {bits_q[15:0], 1'b0};
      quot_q <= {quot_q[15:0], ge};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= req_i.steps;
      end else if (busy_q) begin
        cnt_q <= cnt_q - 5'd1;
        if (cnt_q == 5'd1) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

endmodule

// ----- src/mmcs_back.sv -----
// ----------------------------------------------------------------------------
// mmcs_back
// Engine: target selection, fade step and normalization, result register.
// ----------------------------------------------------------------------------
module mmcs_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  mmcs_pkg::cfg_t      cfg_i,
  input  logic                pop_valid_i,
  input  mmcs_pkg::in_item_t  pop_data_i,
  output logic                pop_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output mmcs_pkg::out_item_t out_data_o
);

  mmcs_pkg::back_state_e state_q, state_d;

  logic [15:0] ratio_q [mmcs_pkg::NumMotions];
  logic [16:0] r_q     [mmcs_pkg::NumMotions];
  logic [16:0] r_d     [mmcs_pkg::NumMotions];
  logic [18:0] sum_q, sum_d;
  logic [1:0]  held_q, last_q, prev_q, idx_q;
  logic [31:0] last_time_q;
  logic        lapd_q;

  mmcs_pkg::in_item_t item_q;
  logic [1:0]  req_q;
  logic [8:0]  sa_out_q;
  logic        first_q;
  logic [31:0] dt_q;
  logic [15:0] t_q;
  logic [15:0] delta_q;

  logic                out_valid_q;
  mmcs_pkg::out_item_t out_q;

  logic               div_start, div_done;
  mmcs_pkg::div_req_t div_req;
  logic [16:0]        div_quot;

  // selection from the head item
  logic        unsafe, sw, first_now;
  logic [1:0]  req_adj, held_new;
  logic [8:0]  sa_new;
  logic [15:0] t_sel, t_new;
  logic [33:0] num;
  logic        slot_free;
  logic [1:0]  mode;
  logic [15:0] q_clip;

  assign first_now = (last_time_q == 32'd0);
  assign unsafe    = !pop_data_i.contact_safe && cfg_i.use_contact;
  assign req_adj   = (pop_data_i.requested_motion == mmcs_pkg::MOT_WALK &&
                      (unsafe || pop_data_i.enforce_stand)) ?
                     mmcs_pkg::MOT_STAND : pop_data_i.requested_motion;
  assign sw = (last_q == mmcs_pkg::MOT_WALK && (pop_data_i.leaving_possible || unsafe)) ||
              last_q == mmcs_pkg::MOT_STAND || last_q == mmcs_pkg::MOT_SPECIAL ||
              (req_adj == mmcs_pkg::MOT_SPECIAL && pop_data_i.special_is_stand_up);
  assign held_new = (!first_now && sw) ? req_adj : held_q;

  always_comb begin
    if (first_now) sa_new = mmcs_pkg::SA_DEFAULT;
    else if (req_adj == mmcs_pkg::MOT_SPECIAL) sa_new = {1'b0, pop_data_i.special_action};
    else if (held_new == mmcs_pkg::MOT_SPECIAL) sa_new = mmcs_pkg::SA_NONE;
    else sa_new = mmcs_pkg::SA_DEFAULT;
    case (held_new)
      mmcs_pkg::MOT_WALK:    t_sel = cfg_i.time_walk;
      mmcs_pkg::MOT_BIKE:    t_sel = cfg_i.time_bike;
      mmcs_pkg::MOT_SPECIAL: t_sel = cfg_i.time_special;
      default:               t_sel = cfg_i.time_stand;
    endcase
    if (prev_q == mmcs_pkg::MOT_SPECIAL && lapd_q) t_sel = cfg_i.time_play_dead;
    t_new = (t_sel == 16'd0) ? 16'd1 : t_sel;
  end

  always_comb begin
    sum_d = '0;
    for (int i = 0; i < mmcs_pkg::NumMotions; i++) begin
      if (2'(i) == held_q) r_d[i] = {1'b0, ratio_q[i]} + {1'b0, delta_q};
      else if (ratio_q[i] > delta_q) r_d[i] = {1'b0, ratio_q[i] - delta_q};
      else r_d[i] = '0;
      sum_d = sum_d + {2'd0, r_d[i]};
    end
  end

  assign num       = {2'b00, r_q[idx_q], 15'd0} + {16'd0, sum_q[18:1]};
  assign slot_free = !out_valid_q || !out_stall_i;
  assign q_clip    = (div_quot > {1'b0, mmcs_pkg::ONE_Q15}) ? mmcs_pkg::ONE_Q15
                                                             : div_quot[15:0];
  assign mode = (ratio_q[mmcs_pkg::MOT_SPECIAL] == mmcs_pkg::ONE_Q15) ? mmcs_pkg::MODE_ACTIVE :
                (held_q == mmcs_pkg::MOT_SPECIAL) ? mmcs_pkg::MODE_FIRST :
                mmcs_pkg::MODE_INACTIVE;

  always_comb begin
    state_d   = state_q;
    pop_o     = 1'b0;
    div_start = 1'b0;
    div_req   = '0;
    case (state_q)
      mmcs_pkg::ST_IDLE: begin
        if (pop_valid_i) begin
          pop_o   = 1'b1;
          state_d = first_now ? mmcs_pkg::ST_FIN : mmcs_pkg::ST_DELTA;
        end
      end
      mmcs_pkg::ST_DELTA: begin
        if (dt_q >= {16'd0, t_q}) begin
          state_d = mmcs_pkg::ST_SUM;
        end else begin
          div_start     = 1'b1;
          div_req.rem   = dt_q[18:0];
          div_req.bits  = '0;
          div_req.den   = {3'd0, t_q};
          div_req.steps = 5'd15;
          state_d       = mmcs_pkg::ST_DWAIT;
        end
      end
      mmcs_pkg::ST_DWAIT: if (div_done) state_d = mmcs_pkg::ST_SUM;
      mmcs_pkg::ST_SUM:   state_d = mmcs_pkg::ST_NORM;
      mmcs_pkg::ST_NORM: begin
        if (sum_q == 19'd0) begin
          if (idx_q == 2'd3) state_d = mmcs_pkg::ST_FIN;
        end else begin
          div_start     = 1'b1;
          div_req.rem   = {2'd0, num[33:17]};
          div_req.bits  = num[16:0];
          div_req.den   = sum_q;
          div_req.steps = 5'd17;
          state_d       = mmcs_pkg::ST_NWAIT;
        end
      end
      mmcs_pkg::ST_NWAIT: begin
        if (div_done) state_d = (idx_q == 2'd3) ? mmcs_pkg::ST_FIN : mmcs_pkg::ST_NORM;
      end
      mmcs_pkg::ST_FIN:   if (slot_free) state_d = mmcs_pkg::ST_IDLE;
      default:            state_d = mmcs_pkg::ST_IDLE;
    endcase
  end

  mmcs_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .req_i   (div_req),
    .done_o  (div_done),
    .quot_o  (div_quot)
  );

  always_ff @(posedge clk_i) begin
    case (state_q)
      mmcs_pkg::ST_IDLE: begin
        item_q   <= pop_data_i;
        req_q    <= req_adj;
        sa_out_q <= sa_new;
        dt_q     <= pop_data_i.time_ms - last_time_q;
        t_q      <= t_new;
      end
      mmcs_pkg::ST_DELTA: delta_q <= mmcs_pkg::ONE_Q15;
      mmcs_pkg::ST_DWAIT: if (div_done) delta_q <= div_quot[15:0];
      mmcs_pkg::ST_SUM: begin
        for (int i = 0; i < mmcs_pkg::NumMotions; i++) r_q[i] <= r_d[i];
        sum_q <= sum_d;
      end
      default: ;
    endcase
    if (state_q == mmcs_pkg::ST_FIN && slot_free) begin
      out_q.target_motion      <= held_q;
      out_q.ratio_walk         <= ratio_q[mmcs_pkg::MOT_WALK];
      out_q.ratio_bike         <= ratio_q[mmcs_pkg::MOT_BIKE];
      out_q.ratio_special      <= ratio_q[mmcs_pkg::MOT_SPECIAL];
      out_q.ratio_stand        <= ratio_q[mmcs_pkg::MOT_STAND];
      out_q.special_mode       <= mode;
      out_q.special_action_out <= sa_out_q;
      out_q.walk_forward       <= !first_q && req_q == mmcs_pkg::MOT_WALK &&
                                  ratio_q[mmcs_pkg::MOT_WALK] == mmcs_pkg::ONE_Q15;
      out_q.bike_forward       <= !first_q && req_q == mmcs_pkg::MOT_BIKE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= mmcs_pkg::ST_IDLE;
      for (int i = 0; i < mmcs_pkg::NumMotions; i++) ratio_q[i] <= '0;
      ratio_q[mmcs_pkg::MOT_STAND] <= mmcs_pkg::ONE_Q15;
      held_q      <= mmcs_pkg::MOT_STAND;
      last_q      <= mmcs_pkg::MOT_STAND;
      prev_q      <= mmcs_pkg::MOT_STAND;
      last_time_q <= '0;
      lapd_q      <= 1'b0;
      idx_q       <= '0;
      first_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (out_valid_q && !out_stall_i) out_valid_q <= 1'b0;
      case (state_q)
        mmcs_pkg::ST_IDLE: begin
          if (pop_valid_i) begin
            held_q  <= held_new;
            first_q <= first_now;
            idx_q   <= '0;
          end
        end
        mmcs_pkg::ST_NORM: begin
          if (sum_q == 19'd0) begin
            ratio_q[idx_q] <= (idx_q == held_q) ? mmcs_pkg::ONE_Q15 : 16'd0;
            idx_q          <= idx_q + 2'd1;
          end
        end
        mmcs_pkg::ST_NWAIT: begin
          if (div_done) begin
            ratio_q[idx_q] <= q_clip;
            idx_q          <= idx_q + 2'd1;
          end
        end
        mmcs_pkg::ST_FIN: begin
          if (slot_free) begin
            out_valid_q <= 1'b1;
            last_time_q <= item_q.time_ms;
            if (last_q != held_q) prev_q <= last_q;
            last_q <= held_q;
            if (!first_q && mode == mmcs_pkg::MODE_ACTIVE && sa_out_q != mmcs_pkg::SA_NONE)
            begin
              lapd_q <= (req_q == mmcs_pkg::MOT_SPECIAL) ? item_q.special_is_play_dead
                                                        : 1'b1;
            end
          end
        end
        default: ;
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ----- src/motion_mode_crossfade_selector_core.sv -----
// ----------------------------------------------------------------------------
// motion_mode_crossfade_selector_core
// Motion target selection and Q1.15 blend-ratio cross-fade, one result per
// frame transfer.
// ----------------------------------------------------------------------------
// Each frame takes one pass of the engine, which uses the shared bit-serial
// divider for the fade step when the elapsed time is below the transition
// time and for each of the four normalizations with a nonzero sum; a fade
// step that saturates needs no division, and the first frame after reset
// skips both; a stalled result holds the engine until the register is free.
// A two-entry input queue and the result register let frames come in while a
// result waits to be taken.
module motion_mode_crossfade_selector_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  mmcs_pkg::in_item_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output mmcs_pkg::out_item_t out_data_o,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [4:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  mmcs_pkg::cfg_t     cfg_q;
  mmcs_pkg::in_item_t pop_data;
  logic               pop_valid, pop;
  logic [2:0]         reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.use_contact    <= 1'b1;
      cfg_q.time_walk      <= 16'd790;
      cfg_q.time_bike      <= 16'd600;
      cfg_q.time_special   <= 16'd200;
      cfg_q.time_stand     <= 16'd600;
      cfg_q.time_play_dead <= 16'd2000;
    end else if (psel && penable && pwrite) begin
      case (reg_idx)
        mmcs_pkg::REG_USE_CONTACT:   cfg_q.use_contact    <= pwdata[0];
        mmcs_pkg::REG_TIME_WALK:     cfg_q.time_walk      <= pwdata[15:0];
        mmcs_pkg::REG_TIME_BIKE:     cfg_q.time_bike      <= pwdata[15:0];
        mmcs_pkg::REG_TIME_SPECIAL:  cfg_q.time_special   <= pwdata[15:0];
        mmcs_pkg::REG_TIME_STAND:    cfg_q.time_stand     <= pwdata[15:0];
        mmcs_pkg::REG_TIME_PLAYDEAD: cfg_q.time_play_dead <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      mmcs_pkg::REG_USE_CONTACT:   prdata = {31'd0, cfg_q.use_contact};
      mmcs_pkg::REG_TIME_WALK:     prdata = {16'd0, cfg_q.time_walk};
      mmcs_pkg::REG_TIME_BIKE:     prdata = {16'd0, cfg_q.time_bike};
      mmcs_pkg::REG_TIME_SPECIAL:  prdata = {16'd0, cfg_q.time_special};
      mmcs_pkg::REG_TIME_STAND:    prdata = {16'd0, cfg_q.time_stand};
      mmcs_pkg::REG_TIME_PLAYDEAD: prdata = {16'd0, cfg_q.time_play_dead};
      default:                     prdata = 32'd0;
    endcase
  end

  mmcs_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .pop_valid_o (pop_valid),
    .pop_data_o  (pop_data),
    .pop_i       (pop)
  );

  mmcs_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .pop_valid_i (pop_valid),
    .pop_data_i  (pop_data),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

// ----- src/mmcs_checker.sv -----
// ----------------------------------------------------------------------------
// mmcs_checker
// Port-level checks on the result channel of the selector.
// ----------------------------------------------------------------------------
`include "motion_mode_crossfade_selector_core_macros.svh"

module mmcs_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                out_valid_o,
  input logic                out_stall_i,
  input mmcs_pkg::out_item_t out_data_o
);

  logic [17:0] rsum;

  assign rsum = {2'd0, out_data_o.ratio_walk} + {2'd0, out_data_o.ratio_bike} +
                {2'd0, out_data_o.ratio_special} + {2'd0, out_data_o.ratio_stand};

  `MMCS_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i,
    out_valid_o && $stable(out_data_o))
  `MMCS_ASSERT_NOW(a_ratio_sum, clk_i, rst_ni, out_valid_o,
    rsum >= 18'd32766 && rsum <= 18'd32770)
  `MMCS_ASSERT_NOW(a_walk_fwd, clk_i, rst_ni, out_valid_o && out_data_o.walk_forward,
    out_data_o.ratio_walk == mmcs_pkg::ONE_Q15)
  `MMCS_ASSERT_NOW(a_mode_active, clk_i, rst_ni,
    out_valid_o && out_data_o.special_mode == mmcs_pkg::MODE_ACTIVE,
    out_data_o.ratio_special == mmcs_pkg::ONE_Q15)

endmodule

bind motion_mode_crossfade_selector_core mmcs_checker u_mmcs_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);
